// ===== rtl/breadcrumb_waypoint_stack_top_defines.svh =====
// ----------------------------------------------------------------------------
// Breadcrumb waypoint stack assertion macros
// Concurrent assertion wrappers on clk_i; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef BREADCRUMB_WAYPOINT_STACK_TOP_DEFINES_SVH
`define BREADCRUMB_WAYPOINT_STACK_TOP_DEFINES_SVH

`ifndef SYNTH
`define BWS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bws assertion failed");
`define BWS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("bws assertion failed");
`else
`define BWS_ASSERT(lbl, prop)
`define BWS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== rtl/bws_pkg.sv =====
// ----------------------------------------------------------------------------
// Breadcrumb waypoint stack package
// Shared widths, codes, reset values and interface types.
// ----------------------------------------------------------------------------
package bws_pkg;

  localparam int StackDepth = 1024;
  localparam int CoordW     = 32;
  localparam int EntryW     = 3 * CoordW;
  localparam int MinStepW   = 31;
  localparam int PopW       = 16;
  localparam int KindW      = 3;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 31;

  localparam logic [KindW-1:0] KindAdd   = 3'd0;
  localparam logic [KindW-1:0] KindPeek  = 3'd1;
  localparam logic [KindW-1:0] KindNext  = 3'd2;
  localparam logic [KindW-1:0] KindStop  = 3'd3;
  localparam logic [KindW-1:0] KindStart = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgMinStep  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPopLimit = 2'd1;

  localparam logic [MinStepW-1:0] MinStepReset  = 31'd262144;
  localparam logic [PopW-1:0]     PopLimitReset = 16'd10000;
  localparam logic [CoordW-1:0]   Sentinel      = 32'hFFFE_0000;

  typedef struct packed {
    logic done;
    logic far;
  } dist_status_t;

endpackage

// ===== rtl/bws_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bws_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bws_dist.sv =====
// ----------------------------------------------------------------------------
// Breadcrumb waypoint stack step-distance unit
// Squares dx, dy and the minimum step on one shared multiplier, then compares.
// ----------------------------------------------------------------------------
module bws_dist (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bws_pkg::CoordW-1:0]     top_x_i,
  input  logic [bws_pkg::CoordW-1:0]     top_y_i,
  input  logic [bws_pkg::CoordW-1:0]     pos_x_i,
  input  logic [bws_pkg::CoordW-1:0]     pos_y_i,
  input  logic [bws_pkg::MinStepW-1:0]   min_step_i,
  output bws_pkg::dist_status_t          status_o
);

  localparam int W  = bws_pkg::CoordW;
  localparam int PW = 2 * W;

  localparam logic [2:0] D_IDLE = 3'd0;
  localparam logic [2:0] D_SQX  = 3'd1;
  localparam logic [2:0] D_SQY  = 3'd2;
  localparam logic [2:0] D_SQM  = 3'd3;
  localparam logic [2:0] D_CMP  = 3'd4;

  function automatic logic [W-1:0] abs_diff(input logic [W-1:0] a, input logic [W-1:0] b);
    logic signed [W:0] d;
    logic        [W:0] m;
    d = $signed({a[W-1], a}) - $signed({b[W-1], b});
    m = d[W] ? (~d + 1'b1) : d;
    return m[W-1:0];
  endfunction

  logic [2:0]    state_q, state_d;
  logic [W-1:0]  dx_q, dy_q;
  logic [W-1:0]  m_q;
  logic [PW-1:0] sx_q, sy_q, mm_q;
  logic [W-1:0]  op;
  logic [PW-1:0] prod;
  logic [PW:0]   sum;

  always_comb begin
    case (state_q)
      D_SQX:   op = dx_q;
      D_SQY:   op = dy_q;
      default: op = m_q;
    endcase
  end

  assign prod = op * op;
  assign sum  = {1'b0, sx_q} + {1'b0, sy_q};

  always_comb begin
    case (state_q)
      D_IDLE:  state_d = start_i ? D_SQX : D_IDLE;
      D_SQX:   state_d = D_SQY;
      D_SQY:   state_d = D_SQM;
      D_SQM:   state_d = D_CMP;
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE && start_i) begin
      dx_q <= abs_diff(top_x_i, pos_x_i);
      dy_q <= abs_diff(top_y_i, pos_y_i);
      m_q  <= {1'b0, min_step_i};
    end
    if (state_q == D_SQX) begin
      sx_q <= prod;
    end
    if (state_q == D_SQY) begin
      sy_q <= prod;
    end
    if (state_q == D_SQM) begin
      mm_q <= prod;
    end
  end

  assign status_o.done = (state_q == D_CMP);
  assign status_o.far  = sum > {1'b0, mm_q};

endmodule

// ===== rtl/breadcrumb_waypoint_stack_top.sv =====
// ----------------------------------------------------------------------------
// Breadcrumb waypoint stack
// Stack of Q16.16 x,y,z positions kept in one synchronous RAM. A stop, start,
// dropped add or unused kind is done in its accept cycle; an add onto an empty
// stack writes at once in its accept cycle. Peek and next go through top read,
// result capture with pop and output register load. An add onto a non-empty
// stack goes through the top-entry read and the distance unit, which squares
// dx, dy and the minimum step in turn on one 32x32 multiplier before a 65-bit
// compare and the write-back. One item is worked at a time; a finished result
// waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
`include "breadcrumb_waypoint_stack_top_defines.svh"

module breadcrumb_waypoint_stack_top #(
  parameter int StackDepth = bws_pkg::StackDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bws_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bws_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bws_pkg::KindW-1:0]     kind_i,
  input  logic signed [bws_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [bws_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [bws_pkg::CoordW-1:0] pos_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [bws_pkg::CoordW-1:0] way_x_o,
  output logic signed [bws_pkg::CoordW-1:0] way_y_o,
  output logic signed [bws_pkg::CoordW-1:0] way_z_o,
  output logic                          way_valid_o
);

  localparam int W     = bws_pkg::CoordW;
  localparam int EW    = bws_pkg::EntryW;
  localparam int PopW  = bws_pkg::PopW;
  localparam int AddrW = $clog2(StackDepth);
  localparam int CntW  = $clog2(StackDepth + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIST = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [bws_pkg::KindW-1:0]     kind_q;
  logic [W-1:0]                  px_q, py_q, pz_q;
  logic [CntW-1:0]               count_q, count_d, cnt_m1;
  logic [PopW-1:0]               pops_q, pops_d;
  logic                          stopped_q, stopped_d;
  logic [bws_pkg::MinStepW-1:0]  min_step_q;
  logic [PopW-1:0]               pop_limit_q;
  logic [W-1:0]                  res_x_q, res_y_q, res_z_q;
  logic                          res_v_q;
  logic [W-1:0]                  out_x_q, out_y_q, out_z_q;
  logic                          out_v_q;
  logic                          out_valid_q;

  logic                          in_acc, can_add, direct_push, need_read;
  logic                          dist_start, late_push, serve, pop;
  logic                          out_free, out_load, res_real;
  logic                          ram_we;
  logic [AddrW-1:0]              top_addr, push_addr;
  logic [EW-1:0]                 ram_wdata, ram_rdata;
  bws_pkg::dist_status_t         dist_st;

  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cnt_m1      = count_q - CntW'(1);
  assign top_addr    = cnt_m1[AddrW-1:0];
  assign push_addr   = count_q[AddrW-1:0];
  assign can_add     = !stopped_q && (count_q < CntW'(StackDepth));
  assign direct_push = in_acc && (kind_i == bws_pkg::KindAdd) && can_add
                       && (count_q == '0);
  assign need_read   = in_acc && (((kind_i == bws_pkg::KindAdd) && can_add
                       && (count_q != '0)) || (kind_i == bws_pkg::KindPeek)
                       || (kind_i == bws_pkg::KindNext));
  assign dist_start  = (state_q == S_READ) && (kind_q == bws_pkg::KindAdd);
  assign late_push   = (state_q == S_DIST) && dist_st.done && dist_st.far;
  assign ram_we      = direct_push || late_push;
  assign ram_wdata   = direct_push ? {pos_z_i, pos_y_i, pos_x_i} : {pz_q, py_q, px_q};
  assign serve       = (count_q != '0) && (pops_q < pop_limit_q);
  assign pop         = (state_q == S_READ) && (kind_q == bws_pkg::KindNext) && serve
                       && (count_q > CntW'(1));
  assign res_real    = (kind_q == bws_pkg::KindNext) ? (count_q != '0) : serve;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == S_OUT) && out_free;

  bws_ram #(
    .Width (EW),
    .Depth (StackDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (push_addr),
    .wdata_i (ram_wdata),
    .re_i    (need_read),
    .raddr_i (top_addr),
    .rdata_o (ram_rdata)
  );

  bws_dist u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dist_start),
    .top_x_i    (ram_rdata[W-1:0]),
    .top_y_i    (ram_rdata[2*W-1:W]),
    .pos_x_i    (px_q),
    .pos_y_i    (py_q),
    .min_step_i (min_step_q),
    .status_o   (dist_st)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pops_d    = pops_q;
    stopped_d = stopped_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (kind_i)
            bws_pkg::KindStop:  stopped_d = 1'b1;
            bws_pkg::KindStart: begin
              stopped_d = 1'b0;
              pops_d    = '0;
            end
            default: ;
          endcase
          if (direct_push) begin
            count_d = count_q + CntW'(1);
          end
          if (need_read) begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        if (kind_q == bws_pkg::KindAdd) begin
          state_d = S_DIST;
        end else begin
          state_d = S_OUT;
          if (pop) begin
            count_d = cnt_m1;
            pops_d  = pops_q + PopW'(1);
          end
        end
      end
      S_DIST: begin
        if (dist_st.done) begin
          state_d = S_IDLE;
          if (dist_st.far) begin
            count_d = count_q + CntW'(1);
          end
        end
      end
      default: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pops_q      <= '0;
      stopped_q   <= 1'b0;
      min_step_q  <= bws_pkg::MinStepReset;
      pop_limit_q <= bws_pkg::PopLimitReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pops_q    <= pops_d;
      stopped_q <= stopped_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bws_pkg::CfgMinStep:  min_step_q  <= cfg_data_i;
          bws_pkg::CfgPopLimit: pop_limit_q <= cfg_data_i[PopW-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      pz_q   <= pos_z_i;
    end
    if ((state_q == S_READ) && (kind_q != bws_pkg::KindAdd)) begin
      res_v_q <= res_real;
      res_x_q <= res_real ? ram_rdata[W-1:0]      : bws_pkg::Sentinel;
      res_y_q <= res_real ? ram_rdata[2*W-1:W]    : bws_pkg::Sentinel;
      res_z_q <= res_real ? ram_rdata[3*W-1:2*W]  : bws_pkg::Sentinel;
    end
    if (out_load) begin
      out_x_q <= res_x_q;
      out_y_q <= res_y_q;
      out_z_q <= res_z_q;
      out_v_q <= res_v_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign way_x_o     = out_x_q;
  assign way_y_o     = out_y_q;
  assign way_z_o     = out_z_q;
  assign way_valid_o = out_v_q;

  `BWS_ASSERT(a_count_bound, count_q <= CntW'(StackDepth))
  `BWS_ASSERT(a_push_room, ram_we |-> count_q < CntW'(StackDepth))
  `BWS_ASSERT(a_pop_keeps_one, pop |-> count_q > CntW'(1))
  `BWS_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> $past(state_q) == S_OUT)
  `BWS_ASSERT(a_dist_done_owned, dist_st.done |-> state_q == S_DIST)

endmodule

// ===== sim/bws_waypoint_checker.sv =====
// ----------------------------------------------------------------------------
// Breadcrumb waypoint stack checker
// Watches the configuration port and both channels. Keeps its own copy of the
// stack, the pop count and the stop flag, works out the waypoint that every
// accepted peek or next must return, and compares each returned beat field by
// field with the oldest waypoint still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bws_waypoint_checker
  import bws_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [KindW-1:0]    kind_i,
  input  logic [CoordW-1:0]   pos_x_i,
  input  logic [CoordW-1:0]   pos_y_i,
  input  logic [CoordW-1:0]   pos_z_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [CoordW-1:0]   way_x_i,
  input  logic [CoordW-1:0]   way_y_i,
  input  logic [CoordW-1:0]   way_z_i,
  input  logic                way_valid_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int IdxW = $clog2(StackDepth);
  localparam int SqW  = 2 * CoordW + 3;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic              ok;
  } waypoint_t;

  logic [CoordW-1:0]   crumb_x [StackDepth];
  logic [CoordW-1:0]   crumb_y [StackDepth];
  logic [CoordW-1:0]   crumb_z [StackDepth];
  int unsigned         crumb_count;
  logic [PopW-1:0]     pops_done;
  logic                adding_stopped;
  logic [MinStepW-1:0] min_step;
  logic [PopW-1:0]     pop_limit;
  waypoint_t           owed_waypoints[$];
  int                  shown;

  function automatic logic [CoordW:0] coord_gap(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
    logic signed [CoordW:0] d;
    d = $signed({a[CoordW-1], a}) - $signed({b[CoordW-1], b});
    return d[CoordW] ? -d : d;
  endfunction

  function automatic logic beyond_min_step(logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    logic [SqW-1:0] ax;
    logic [SqW-1:0] ay;
    logic [SqW-1:0] mm;
    ax = SqW'(coord_gap(x, crumb_x[IdxW'(crumb_count - 1)]));
    ay = SqW'(coord_gap(y, crumb_y[IdxW'(crumb_count - 1)]));
    mm = SqW'(min_step);
    return (ax * ax + ay * ay) > (mm * mm);
  endfunction

  task automatic owe_waypoint(logic from_top);
    waypoint_t w;
    if (from_top) begin
      w.x  = crumb_x[IdxW'(crumb_count - 1)];
      w.y  = crumb_y[IdxW'(crumb_count - 1)];
      w.z  = crumb_z[IdxW'(crumb_count - 1)];
      w.ok = 1'b1;
    end else begin
      w.x  = Sentinel;
      w.y  = Sentinel;
      w.z  = Sentinel;
      w.ok = 1'b0;
    end
    owed_waypoints.push_back(w);
  endtask

  task automatic predict_waypoint(logic [KindW-1:0] kind, logic [CoordW-1:0] x,
                                  logic [CoordW-1:0] y, logic [CoordW-1:0] z);
    logic serve;
    serve = (crumb_count > 0) && (pops_done < pop_limit);
    case (kind)
      KindAdd: begin
        if (!adding_stopped && crumb_count < StackDepth) begin
          if (crumb_count == 0 || beyond_min_step(x, y)) begin
            crumb_x[IdxW'(crumb_count)] = x;
            crumb_y[IdxW'(crumb_count)] = y;
            crumb_z[IdxW'(crumb_count)] = z;
            crumb_count++;
          end
        end
      end
      KindPeek: owe_waypoint(serve);
      KindNext: begin
        owe_waypoint(crumb_count > 0);
        if (serve && crumb_count > 1) begin
          crumb_count--;
          pops_done++;
        end
      end
      KindStop: adding_stopped = 1'b1;
      KindStart: begin
        adding_stopped = 1'b0;
        pops_done      = '0;
      end
      default: ;
    endcase
  endtask

  task automatic report_fault(string what, logic [CoordW-1:0] want, logic [CoordW-1:0] got);
    fail_count_o++;
    if (shown < 10) begin
      shown++;
      $display("%0t waypoint %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  task automatic check_field(string what, logic [CoordW-1:0] want, logic [CoordW-1:0] got);
    if (want !== got) report_fault(what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    waypoint_t want;
    if (!rst_ni) begin
      crumb_count    = 0;
      pops_done      = '0;
      adding_stopped = 1'b0;
      min_step       = MinStepReset;
      pop_limit      = PopLimitReset;
      owed_waypoints.delete();
      shown          = 0;
      fail_count_o   = 0;
      pending_o      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMinStep:  min_step  = cfg_data_i[MinStepW-1:0];
          CfgPopLimit: pop_limit = cfg_data_i[PopW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (owed_waypoints.size() == 0) begin
          report_fault("beat with nothing owed, x", '0, way_x_i);
        end else begin
          want = owed_waypoints.pop_front();
          check_field("x", want.x, way_x_i);
          check_field("y", want.y, way_y_i);
          check_field("z", want.z, way_z_i);
          check_field("valid flag", CoordW'(want.ok), CoordW'(way_valid_i));
        end
      end
      if (in_valid_i && !in_stall_i) predict_waypoint(kind_i, pos_x_i, pos_y_i, pos_z_i);
      pending_o = owed_waypoints.size();
    end
  end

endmodule

// ===== sim/tb_breadcrumb_waypoint_stack_top.sv =====
// ----------------------------------------------------------------------------
// Breadcrumb waypoint stack testbench
// Drives adds, peeks, nexts, stop and start beats in random bursts against a
// randomly stalling receiver, first a short directed sequence, then random
// phases under several step and pop limit settings, including a full stack
// and a long receiver hold. A separate checker predicts every waypoint.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_breadcrumb_waypoint_stack_top;
  import bws_pkg::*;

  localparam int IdleLimit    = 4000;
  localparam int RxHoldCycles = 300;
  localparam int SettleCycles = 10;

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i  = '0;
  logic [CfgDataW-1:0]      cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [KindW-1:0]         kind_i     = KindPeek;
  logic signed [CoordW-1:0] pos_x_i    = '0;
  logic signed [CoordW-1:0] pos_y_i    = '0;
  logic signed [CoordW-1:0] pos_z_i    = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [CoordW-1:0] way_x_o;
  logic signed [CoordW-1:0] way_y_o;
  logic signed [CoordW-1:0] way_z_o;
  logic                     way_valid_o;

  int                checker_fails;
  int                waypoints_owed;
  int                idle_cycles = 0;
  int                hold_asks   = 0;
  int                burst_left  = 1;
  int                gap_max     = 0;
  logic [CoordW-1:0] cur_min     = CoordW'(MinStepReset);
  logic [CoordW-1:0] last_x      = '0;
  logic [CoordW-1:0] last_y      = '0;

  breadcrumb_waypoint_stack_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .way_x_o     (way_x_o),
    .way_y_o     (way_y_o),
    .way_z_o     (way_z_o),
    .way_valid_o (way_valid_o)
  );

  bws_waypoint_checker waypoint_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .kind_i       (kind_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .way_x_i      (way_x_o),
    .way_y_i      (way_y_o),
    .way_z_i      (way_z_o),
    .way_valid_i  (way_valid_o),
    .fail_count_o (checker_fails),
    .pending_o    (waypoints_owed)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall pattern, plus a long hold whenever one is asked
  initial begin
    int holds_served;
    int run_left;
    int mode;
    int tick;
    holds_served = 0;
    run_left     = 0;
    mode         = 0;
    tick         = 0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != holds_served) begin
        holds_served++;
        out_stall_i <= 1'b1;
        for (int c = 0; c < RxHoldCycles; c++) @(posedge clk_i);
      end
      if (run_left == 0) begin
        mode     = $urandom_range(0, 3);
        run_left = $urandom_range(16, 128);
      end
      run_left--;
      tick++;
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= 1'($urandom_range(0, 1));
        2: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ((tick % 7) < 3);
      endcase
    end
  end

  task automatic offer_beat(logic [KindW-1:0] kind, logic [CoordW-1:0] x,
                            logic [CoordW-1:0] y, logic [CoordW-1:0] z);
    int gap;
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    pos_x_i    <= x;
    pos_y_i    <= y;
    pos_z_i    <= z;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain_waypoints;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (waypoints_owed != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    if (idx == CfgMinStep) cur_min = CoordW'(data);
  endtask

  task automatic setup_phase(logic [CfgDataW-1:0] min_step, logic [CfgDataW-1:0] limit);
    drain_waypoints();
    write_reg(CfgMinStep, min_step);
    write_reg(CfgPopLimit, limit);
    gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
  endtask

  function automatic logic [CoordW-1:0] pick_coord(logic [CoordW-1:0] base);
    logic [CoordW-1:0] off;
    case ($urandom_range(0, 5))
      0, 1: off = $urandom_range(0, cur_min >> 1);
      2, 3: off = $urandom_range(cur_min >> 1, cur_min + (cur_min >> 1));
      4: return $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
    return $urandom_range(0, 1) ? base + off : base - off;
  endfunction

  task automatic run_mixed(int n);
    int roll;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        x = pick_coord(last_x);
        y = pick_coord(last_y);
        offer_beat(KindAdd, x, y, $urandom);
        last_x = x;
        last_y = y;
      end else if (roll < 66) begin
        offer_beat(KindPeek, $urandom, $urandom, $urandom);
      end else if (roll < 90) begin
        offer_beat(KindNext, $urandom, $urandom, $urandom);
      end else if (roll < 92) begin
        offer_beat(KindStop, $urandom, $urandom, $urandom);
      end else if (roll < 98) begin
        offer_beat(KindStart, $urandom, $urandom, $urandom);
      end else begin
        offer_beat(KindW'($urandom_range(KindStart + 1, (1 << KindW) - 1)), $urandom,
                   $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_beat(KindPeek, '0, '0, '0);
    offer_beat(KindNext, '1, '1, '1);
    offer_beat(KindAdd, '0, '0, 32'h0001_2345);
    offer_beat(KindAdd, 32'h0001_0000, '0, '0);
    offer_beat(KindAdd, 32'h0004_0000, '0, '0);
    offer_beat(KindAdd, 32'h0004_0001, '0, 32'hFFFF_0000);
    offer_beat(KindAdd, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    offer_beat(KindAdd, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    offer_beat(KindPeek, '0, '0, '0);
    offer_beat(KindNext, '0, '0, '0);
    offer_beat(KindStop, '0, '0, '0);
    offer_beat(KindAdd, 32'h7000_0000, '0, '1);
    offer_beat(KindPeek, '0, '0, '0);
    offer_beat(KindStart, '0, '0, '0);
    for (int k = KindStart + 1; k < (1 << KindW); k++) offer_beat(KindW'(k), '1, '1, '1);
    offer_beat(KindNext, '0, '0, '0);
    offer_beat(KindNext, '0, '0, '0);
    offer_beat(KindNext, '0, '0, '0);
    offer_beat(KindPeek, '0, '0, '0);

    drain_waypoints();
    write_reg(CfgPopLimit, '0);
    write_reg(CfgMinStep, '0);
    for (int i = CfgPopLimit + 1; i < (1 << CfgIdxW); i++) begin
      write_reg(CfgIdxW'(i), CfgDataW'($urandom));
    end
    offer_beat(KindAdd, 32'h0000_0001, '0, 32'h5555_AAAA);
    offer_beat(KindPeek, '0, '0, '0);
    offer_beat(KindNext, '0, '0, '0);
    offer_beat(KindNext, '0, '0, '0);

    setup_phase(CfgDataW'($urandom_range(32'h1000, 32'h8_0000)),
                CfgDataW'($urandom_range(1, 12)));
    run_mixed(200);

    // fill past the top so the last adds are dropped
    setup_phase('0, CfgDataW'(16'hFFFF));
    offer_beat(KindStart, '0, '0, '0);
    for (int i = 0; i < 1040; i++) begin
      if (i % 64 == 63) offer_beat(KindPeek, $urandom, $urandom, $urandom);
      else offer_beat(KindAdd, $urandom, $urandom, $urandom);
    end

    drain_waypoints();
    hold_asks++;
    for (int i = 0; i < 80; i++) begin
      offer_beat($urandom_range(0, 1) ? KindPeek : KindNext, $urandom, $urandom, $urandom);
    end

    setup_phase(31'h7FFF_FFFF, '0);
    run_mixed(150);

    setup_phase(CfgDataW'($urandom_range(0, 32'h7FFF_FFFF)),
                CfgDataW'($urandom_range(0, 30)));
    for (int i = CfgPopLimit + 1; i < (1 << CfgIdxW); i++) begin
      write_reg(CfgIdxW'(i), CfgDataW'($urandom));
    end
    run_mixed(125);
    setup_phase(CfgDataW'($urandom_range(0, 32'h20_0000)),
                CfgDataW'($urandom_range(0, 16'hFFFF)));
    run_mixed(125);

    drain_waypoints();
    repeat (20) @(posedge clk_i);
    if (checker_fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
